// File: rtl/hrll_pkg.sv
// Shared types, constants and character tables for the HTTP request line locator.
package hrll_pkg;

   // Longest request that is scanned; longer ones are flagged.
   localparam int MAX_REQUEST = 4096;
   // Offset of a byte inside a scanned request.
   localparam int POS_W = $clog2(MAX_REQUEST);
   // Byte count of a request, or an offset one past the last byte.
   localparam int CNT_W = $clog2(MAX_REQUEST + 1);

   // Fixed widths of the result fields and the capacity registers.
   localparam int OFF_W = 12;
   localparam int LEN_W = 13;
   localparam int CAP_W = 13;

   // Common width for compares between counts and capacities, with one spare bit.
   localparam int EXT_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

   // Register indexes of the control port.
   localparam logic CSR_URI_CAPACITY   = 1'b0;
   localparam logic CSR_QUERY_CAPACITY = 1'b1;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 13'd256;

   // Result status codes.
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_NO_METHOD   = 3'd1;
   localparam logic [2:0] ST_NO_BODY     = 3'd2;
   localparam logic [2:0] ST_NO_SLASH    = 3'd3;
   localparam logic [2:0] ST_URI_LONG    = 3'd4;
   localparam logic [2:0] ST_REQUEST_LONG = 3'd5;

   // Method codes.
   localparam logic [1:0] METHOD_NONE    = 2'd0;
   localparam logic [1:0] METHOD_GET     = 2'd1;
   localparam logic [1:0] METHOD_POST    = 2'd2;
   localparam logic [1:0] METHOD_OPTIONS = 2'd3;

   // Bit positions of the method candidates in the match mask.
   localparam int MATCH_GET     = 0;
   localparam int MATCH_POST    = 1;
   localparam int MATCH_OPTIONS = 2;

   // Characters of interest.
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_CR       = 8'h0d;
   localparam logic [7:0] CH_LF       = 8'h0a;
   localparam logic [7:0] CH_SLASH    = 8'h2f;
   localparam logic [7:0] CH_QUESTION = 8'h3f;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5a;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   typedef struct packed {
      logic [7:0] req_byte;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [1:0]       method;
      logic [OFF_W-1:0] uri_start;
      logic [LEN_W-1:0] uri_length;
      logic             query_valid;
      logic [OFF_W-1:0] query_start;
      logic [LEN_W-1:0] query_length;
      logic [OFF_W-1:0] body_start;
   } rsp_word_type;

   // Scan state of a finished request, handed to the result stage.
   typedef struct packed {
      logic             too_long;
      logic [CNT_W-1:0] len;
      logic             leading_done;
      logic [POS_W-1:0] method_start;
      logic [2:0]       match;
      logic             slash_found;
      logic [POS_W-1:0] slash_pos;
      logic             uri_end_found;
      logic [POS_W-1:0] uri_end_pos;
      logic             query_flag;
      logic             query_end_found;
      logic [POS_W-1:0] query_end_pos;
      logic             body_found;
      logic [CNT_W-1:0] body_pos;
   } snap_type;

   // Pipeline moves issued by the top level.
   typedef struct packed {
      logic scan_en;   // input register hands its byte to the scanner
      logic snap_take; // snapshot moves into the result register
      logic rsp_take;  // result register is read out
   } pipe_ctl_type;

   function automatic logic [7:0] get_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h67; // g
         3'd1:    c = 8'h65; // e
         3'd2:    c = 8'h74; // t
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] post_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h70; // p
         3'd1:    c = 8'h6f; // o
         3'd2:    c = 8'h73; // s
         3'd3:    c = 8'h74; // t
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] options_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h6f; // o
         3'd1:    c = 8'h70; // p
         3'd2:    c = 8'h74; // t
         3'd3:    c = 8'h69; // i
         3'd4:    c = 8'h6f; // o
         3'd5:    c = 8'h6e; // n
         3'd6:    c = 8'h73; // s
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// File: rtl/hrll_scan.sv
// Per-byte scanner: method match, slash, URI and query ends, blank line, snapshot register.
module hrll_scan
   import hrll_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pipe_ctl_type pipe,
   input  req_word_type word,
   output logic         snap_valid,
   output snap_type     snap
);

   logic [CNT_W-1:0] position_ff, position_in;
   logic [POS_W-1:0] method_start_ff, method_start_in;
   logic             leading_ff, leading_in;
   logic [2:0]       match_ff, match_in;
   logic             slash_found_ff, slash_found_in;
   logic [POS_W-1:0] slash_pos_ff, slash_pos_in;
   logic             uri_end_found_ff, uri_end_found_in;
   logic [POS_W-1:0] uri_end_pos_ff, uri_end_pos_in;
   logic             query_flag_ff, query_flag_in;
   logic             query_end_found_ff, query_end_found_in;
   logic [POS_W-1:0] query_end_pos_ff, query_end_pos_in;
   logic [1:0]       blank_ff, blank_in;
   logic             body_found_ff, body_found_in;
   logic [CNT_W-1:0] body_pos_ff, body_pos_in;
   logic             too_long_ff, too_long_in;
   logic             snap_valid_ff, snap_valid_in;
   snap_type         snap_ff, snap_in;

   logic [7:0]       b;
   logic [7:0]       lc;
   logic             is_term;
   logic [POS_W-1:0] pos_short;
   logic             lead_cur;
   logic [POS_W-1:0] ms_cur;
   logic [CNT_W-1:0] method_ofs;

   assign b          = word.req_byte;
   assign lc         = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_OFFSET : b;
   assign is_term    = (b == CH_SPACE) || (b == CH_CR) || (b == CH_LF);
   assign pos_short  = position_ff[POS_W-1:0];
   assign lead_cur   = leading_ff || (b != CH_SPACE);
   assign ms_cur     = leading_ff ? method_start_ff : pos_short;
   assign method_ofs = position_ff - CNT_W'(ms_cur);

   always_comb begin
      position_in        = position_ff;
      method_start_in    = method_start_ff;
      leading_in         = leading_ff;
      match_in           = match_ff;
      slash_found_in     = slash_found_ff;
      slash_pos_in       = slash_pos_ff;
      uri_end_found_in   = uri_end_found_ff;
      uri_end_pos_in     = uri_end_pos_ff;
      query_flag_in      = query_flag_ff;
      query_end_found_in = query_end_found_ff;
      query_end_pos_in   = query_end_pos_ff;
      blank_in           = blank_ff;
      body_found_in      = body_found_ff;
      body_pos_in        = body_pos_ff;
      too_long_in        = too_long_ff;
      snap_in            = snap_ff;
      snap_valid_in      = snap_valid_ff && !pipe.snap_take;

      if (pipe.scan_en) begin
         if (!too_long_ff && position_ff >= CNT_W'(MAX_REQUEST)) begin
            too_long_in = 1'b1;
         end else if (!too_long_ff) begin
            leading_in      = lead_cur;
            method_start_in = ms_cur;
            if (lead_cur) begin
               if (method_ofs < CNT_W'(7)) begin
                  if (method_ofs < CNT_W'(3) && lc != get_char(method_ofs[2:0]))
                     match_in[MATCH_GET] = 1'b0;
                  if (method_ofs < CNT_W'(4) && lc != post_char(method_ofs[2:0]))
                     match_in[MATCH_POST] = 1'b0;
                  if (lc != options_char(method_ofs[2:0]))
                     match_in[MATCH_OPTIONS] = 1'b0;
               end
               if (method_ofs >= CNT_W'(3)) begin
                  if (!slash_found_ff) begin
                     if (b == CH_SLASH) begin
                        slash_found_in = 1'b1;
                        slash_pos_in   = pos_short;
                     end
                  end else if (!uri_end_found_ff) begin
                     if (b == CH_QUESTION || is_term) begin
                        uri_end_found_in = 1'b1;
                        uri_end_pos_in   = pos_short;
                        query_flag_in    = (b == CH_QUESTION);
                     end
                  end else if (query_flag_ff && !query_end_found_ff) begin
                     if (is_term) begin
                        query_end_found_in = 1'b1;
                        query_end_pos_in   = pos_short;
                     end
                  end
               end
            end
            // count matched bytes of CR LF CR LF
            if (!body_found_ff) begin
               if (b == CH_CR) begin
                  blank_in = (blank_ff == 2'd2) ? 2'd3 : 2'd1;
               end else if (b == CH_LF) begin
                  if (blank_ff == 2'd1) begin
                     blank_in = 2'd2;
                  end else if (blank_ff == 2'd3) begin
                     body_found_in = 1'b1;
                     body_pos_in   = position_ff + CNT_W'(1);
                     blank_in      = 2'd0;
                  end else begin
                     blank_in = 2'd0;
                  end
               end else begin
                  blank_in = 2'd0;
               end
            end
         end

         if (word.last) begin
            // hand the finished request over and start afresh
            snap_valid_in           = 1'b1;
            snap_in.too_long        = too_long_in;
            snap_in.len             = position_ff + CNT_W'(1);
            snap_in.leading_done    = leading_in;
            snap_in.method_start    = method_start_in;
            snap_in.match           = match_in;
            snap_in.slash_found     = slash_found_in;
            snap_in.slash_pos       = slash_pos_in;
            snap_in.uri_end_found   = uri_end_found_in;
            snap_in.uri_end_pos     = uri_end_pos_in;
            snap_in.query_flag      = query_flag_in;
            snap_in.query_end_found = query_end_found_in;
            snap_in.query_end_pos   = query_end_pos_in;
            snap_in.body_found      = body_found_in;
            snap_in.body_pos        = body_pos_in;

            position_in        = '0;
            method_start_in    = '0;
            leading_in         = 1'b0;
            match_in           = 3'b111;
            slash_found_in     = 1'b0;
            uri_end_found_in   = 1'b0;
            query_flag_in      = 1'b0;
            query_end_found_in = 1'b0;
            blank_in           = 2'd0;
            body_found_in      = 1'b0;
            too_long_in        = 1'b0;
         end else if (!too_long_in) begin
            position_in = position_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff        <= '0;
         method_start_ff    <= '0;
         leading_ff         <= 1'b0;
         match_ff           <= 3'b111;
         slash_found_ff     <= 1'b0;
         uri_end_found_ff   <= 1'b0;
         query_flag_ff      <= 1'b0;
         query_end_found_ff <= 1'b0;
         blank_ff           <= 2'd0;
         body_found_ff      <= 1'b0;
         too_long_ff        <= 1'b0;
         snap_valid_ff      <= 1'b0;
      end else begin
         position_ff        <= position_in;
         method_start_ff    <= method_start_in;
         leading_ff         <= leading_in;
         match_ff           <= match_in;
         slash_found_ff     <= slash_found_in;
         uri_end_found_ff   <= uri_end_found_in;
         query_flag_ff      <= query_flag_in;
         query_end_found_ff <= query_end_found_in;
         blank_ff           <= blank_in;
         body_found_ff      <= body_found_in;
         too_long_ff        <= too_long_in;
         snap_valid_ff      <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slash_pos_ff     <= slash_pos_in;
      uri_end_pos_ff   <= uri_end_pos_in;
      query_end_pos_ff <= query_end_pos_in;
      body_pos_ff      <= body_pos_in;
      snap_ff          <= snap_in;
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

// File: rtl/hrll_result.sv
// Result stage: turns a request snapshot into status, method and offsets; holds the result word.
module hrll_result
   import hrll_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  pipe_ctl_type     pipe,
   input  snap_type         snap,
   input  logic [CAP_W-1:0] uri_capacity,
   input  logic [CAP_W-1:0] query_capacity,
   output logic             rsp_valid,
   output rsp_word_type     rsp_data
);

   logic         valid_ff, valid_in;
   rsp_word_type data_ff, data_in;

   logic [EXT_W-1:0] len_x;
   logic [EXT_W-1:0] start_x;
   logic             ok5;
   logic             ok8;
   logic [EXT_W-1:0] uri_end_x;
   logic [EXT_W-1:0] uri_len_x;
   logic [EXT_W-1:0] query_len_x;

   assign len_x       = EXT_W'(snap.len);
   assign start_x     = EXT_W'(snap.method_start);
   assign ok5         = snap.leading_done && (start_x + EXT_W'(4) < len_x);
   assign ok8         = snap.leading_done && (start_x + EXT_W'(7) < len_x);
   assign uri_end_x   = snap.uri_end_found ? EXT_W'(snap.uri_end_pos) : len_x;
   assign uri_len_x   = uri_end_x - EXT_W'(snap.slash_pos);
   assign query_len_x = EXT_W'(snap.query_end_pos) - EXT_W'(snap.uri_end_pos) - EXT_W'(1);

   always_comb begin
      data_in = '0;
      data_in.status = ST_OK;
      data_in.method = METHOD_NONE;
      if (snap.too_long) begin
         data_in.status = ST_REQUEST_LONG;
      end else begin
         if (snap.match[MATCH_GET] && ok5) begin
            data_in.method = METHOD_GET;
         end else if (snap.match[MATCH_POST] && ok5) begin
            data_in.method = METHOD_POST;
            if (!snap.body_found || EXT_W'(snap.body_pos) >= len_x)
               data_in.status = ST_NO_BODY;
         end else if (snap.match[MATCH_OPTIONS] && ok8) begin
            data_in.method = METHOD_OPTIONS;
         end else begin
            data_in.status = ST_NO_METHOD;
         end

         if (data_in.status == ST_OK) begin
            if (!snap.slash_found || EXT_W'(snap.slash_pos) + EXT_W'(1) >= len_x) begin
               data_in.status = ST_NO_SLASH;
            end else if (uri_len_x >= EXT_W'(uri_capacity)) begin
               data_in.status = ST_URI_LONG;
            end else begin
               data_in.uri_start  = OFF_W'(snap.slash_pos);
               data_in.uri_length = LEN_W'(uri_len_x);
               if (snap.query_flag && snap.query_end_found &&
                   query_len_x != '0 && query_len_x < EXT_W'(query_capacity)) begin
                  data_in.query_valid  = 1'b1;
                  data_in.query_start  = OFF_W'(EXT_W'(snap.uri_end_pos) + EXT_W'(1));
                  data_in.query_length = LEN_W'(query_len_x);
               end
               if (data_in.method == METHOD_POST)
                  data_in.body_start = OFF_W'(snap.body_pos);
            end
         end
      end
   end

   // load on a snapshot move, drop once read out
   assign valid_in = pipe.snap_take || (valid_ff && !pipe.rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe.snap_take) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: rtl/http_request_line_locator_unit.sv
// Top level of the HTTP request line locator: ports, capacity registers, pipeline control.
//
//   channel | ports                          | word
//   --------+--------------------------------+-------------------------------------
//   request | req_valid req_stall req_data   | one request byte plus last flag
//   result  | rsp_valid rsp_stall rsp_data   | status, method, URI/query/body spans
//   control | csr_write csr_index csr_wdata  | uri_capacity (0), query_capacity (1)
//
// One byte is taken per clock unless req_stall holds a last byte; the scanner
// updates its match state as each byte is taken, so there are no bubbles.
// After its last byte, a result passes the input register, the scan snapshot
// register and the result register, in that order, before it leaves.
// Reset is synchronous; it empties all three registers, clears the scan state
// and loads both capacities with 256.
// A stalled result holds in place; the snapshot and input registers keep
// filling behind it, and req_stall rises only once a last byte has nowhere to go.
module http_request_line_locator_unit
   import hrll_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_word_type     req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_word_type     rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [CAP_W-1:0] csr_wdata
);

   logic [CAP_W-1:0] uri_cap_ff, uri_cap_in;
   logic [CAP_W-1:0] query_cap_ff, query_cap_in;

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;

   logic         snap_valid;
   snap_type     snap;
   pipe_ctl_type pipe;
   logic         rsp_free;
   logic         snap_free;
   logic         in_free;

   // capacity registers; to be written only while the block is idle (not enforced here)
   always_comb begin
      uri_cap_in   = uri_cap_ff;
      query_cap_in = query_cap_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_URI_CAPACITY:   uri_cap_in   = csr_wdata;
            CSR_QUERY_CAPACITY: query_cap_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // backward-flowing free signals: each stage may move when the one after it moves
   assign pipe.rsp_take  = rsp_valid && !rsp_stall;
   assign rsp_free       = !rsp_valid || pipe.rsp_take;
   assign pipe.snap_take = snap_valid && rsp_free;
   assign snap_free      = !snap_valid || pipe.snap_take;
   // a byte that is not last only updates scan state, so it never waits
   assign pipe.scan_en   = in_valid_ff && (!in_word_ff.last || snap_free);
   assign in_free        = !in_valid_ff || pipe.scan_en;
   assign req_stall      = !in_free;

   assign in_valid_in = in_free ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         uri_cap_ff   <= CAPACITY_RESET;
         query_cap_ff <= CAPACITY_RESET;
         in_valid_ff  <= 1'b0;
      end else begin
         uri_cap_ff   <= uri_cap_in;
         query_cap_ff <= query_cap_in;
         in_valid_ff  <= in_valid_in;
      end
   end

   // hold the input word until the scanner takes it
   always_ff @(posedge clock) begin
      if (in_free) begin
         in_word_ff <= req_data;
      end
   end

   hrll_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .pipe       (pipe),
      .word       (in_word_ff),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   hrll_result u_result (
      .clock          (clock),
      .reset          (reset),
      .pipe           (pipe),
      .snap           (snap),
      .uri_capacity   (uri_cap_ff),
      .query_capacity (query_cap_ff),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data)
   );

endmodule

// File: rtl/hrll_checker.sv
// Port-level checker for the HTTP request line locator, bound to the top level.
module hrll_checker
   import hrll_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // failures carry no spans
   a_fail_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         rsp_data.uri_length == '0 && !rsp_data.query_valid && rsp_data.body_start == '0)
      else $error("failure result carries spans");

   // over-long request reports no method
   a_long_no_method: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_REQUEST_LONG |-> rsp_data.method == METHOD_NONE)
      else $error("over-long request names a method");

   // a good result always names a method
   a_ok_method: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_OK |-> rsp_data.method != METHOD_NONE)
      else $error("good result without a method");

endmodule

bind http_request_line_locator_unit hrll_checker u_hrll_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: bench/http_request_line_locator_unit_tb.sv
// Self-checking bench for the HTTP request line locator: byte stream in, one span summary out.
module http_request_line_locator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hrll_pkg::*;

   // Bytes that steer the scanner, mixed into noise requests.
   localparam int SPECIAL_COUNT = 8;
   localparam logic [7:0] SPECIAL_BYTES [SPECIAL_COUNT] = '{
      CH_SPACE, CH_CR, CH_LF, CH_SLASH, CH_QUESTION, 8'h47, 8'h70, 8'h6f};
   localparam int PHASES = 7;
   localparam int DRAIN_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_OFF_CYCLES = 300;

   // Span predictor plus the queue of summaries it owes the result channel.
   class locator_scoreboard;
      logic [CAP_W-1:0] uri_limit;
      logic [CAP_W-1:0] query_limit;
      logic [CNT_W-1:0] offset;
      logic [POS_W-1:0] method_at;
      bit               started;
      logic [2:0]       candidates;
      bit               slash_seen, uri_end_seen, query_open, query_end_seen;
      bit               body_seen, overflow;
      logic [CNT_W-1:0] slash_at, uri_end_at, query_end_at, body_at;
      logic [1:0]       blank_run;
      string            method_words[3];
      rsp_word_type     expected_q[$];
      int               errors;
      int               checked;

      function new();
         method_words[MATCH_GET]     = "get";
         method_words[MATCH_POST]    = "post";
         method_words[MATCH_OPTIONS] = "options";
         uri_limit   = CAPACITY_RESET;
         query_limit = CAPACITY_RESET;
         errors  = 0;
         checked = 0;
         restart();
      endfunction

      function void restart();
         offset         = '0;
         method_at      = '0;
         started        = 0;
         candidates     = '1;
         slash_seen     = 0;
         uri_end_seen   = 0;
         query_open     = 0;
         query_end_seen = 0;
         body_seen      = 0;
         overflow       = 0;
         slash_at       = '0;
         uri_end_at     = '0;
         query_end_at   = '0;
         body_at        = '0;
         blank_run      = '0;
      endfunction

      function void set_capacities(logic [CAP_W-1:0] uri_cap, logic [CAP_W-1:0] query_cap);
         uri_limit   = uri_cap;
         query_limit = query_cap;
      endfunction

      function bit is_separator(logic [7:0] b);
         return b == CH_SPACE || b == CH_CR || b == CH_LF;
      endfunction

      function void scan_byte(logic [7:0] b);
         logic [7:0] lc;
         int         d;
         lc = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_OFFSET : b;
         if (!started && b != CH_SPACE) begin
            started   = 1;
            method_at = offset[POS_W-1:0];
         end
         if (started) begin
            d = int'(offset) - int'(method_at);
            for (int k = 0; k < 3; k++)
               if (d < method_words[k].len() && lc != 8'(method_words[k].getc(d)))
                  candidates[k] = 1'b0;
            // the slash search opens three bytes into the method
            if (d >= 3) begin
               if (!slash_seen) begin
                  if (b == CH_SLASH) begin
                     slash_seen = 1;
                     slash_at   = offset;
                  end
               end else if (!uri_end_seen) begin
                  if (b == CH_QUESTION || is_separator(b)) begin
                     uri_end_seen = 1;
                     uri_end_at   = offset;
                     query_open   = (b == CH_QUESTION);
                  end
               end else if (query_open && !query_end_seen) begin
                  if (is_separator(b)) begin
                     query_end_seen = 1;
                     query_end_at   = offset;
                  end
               end
            end
         end
         // CR LF CR LF tracker, frozen once the body is found
         if (!body_seen) begin
            if (b == CH_CR) begin
               blank_run = (blank_run == 2'd2) ? 2'd3 : 2'd1;
            end else if (b == CH_LF) begin
               if (blank_run == 2'd1) begin
                  blank_run = 2'd2;
               end else if (blank_run == 2'd3) begin
                  body_seen = 1;
                  body_at   = offset + 1'b1;
                  blank_run = '0;
               end else begin
                  blank_run = '0;
               end
            end else begin
               blank_run = '0;
            end
         end
      endfunction

      function rsp_word_type summarize();
         rsp_word_type r;
         int           len, uri_end, ulen, qlen, qfrom;
         bit           fits_short, fits_long;
         r = '0;
         if (overflow) begin
            r.status = ST_REQUEST_LONG;
            return r;
         end
         len        = int'(offset) + 1;
         fits_short = started && int'(method_at) + 4 < len;
         fits_long  = started && int'(method_at) + 7 < len;
         if (candidates[MATCH_GET] && fits_short) begin
            r.method = METHOD_GET;
         end else if (candidates[MATCH_POST] && fits_short) begin
            r.method = METHOD_POST;
            if (!body_seen || int'(body_at) >= len) r.status = ST_NO_BODY;
         end else if (candidates[MATCH_OPTIONS] && fits_long) begin
            r.method = METHOD_OPTIONS;
         end else begin
            r.status = ST_NO_METHOD;
         end
         if (r.status != ST_OK) return r;
         if (!slash_seen || int'(slash_at) + 1 >= len) begin
            r.status = ST_NO_SLASH;
            return r;
         end
         uri_end = uri_end_seen ? int'(uri_end_at) : len;
         ulen    = uri_end - int'(slash_at);
         if (ulen >= int'(uri_limit)) begin
            r.status = ST_URI_LONG;
            return r;
         end
         r.uri_start  = slash_at[OFF_W-1:0];
         r.uri_length = ulen[LEN_W-1:0];
         if (query_open && query_end_seen) begin
            qlen  = int'(query_end_at) - int'(uri_end_at) - 1;
            qfrom = int'(uri_end_at) + 1;
            if (qlen > 0 && qlen < int'(query_limit)) begin
               r.query_valid  = 1'b1;
               r.query_start  = qfrom[OFF_W-1:0];
               r.query_length = qlen[LEN_W-1:0];
            end
         end
         if (r.method == METHOD_POST) r.body_start = body_at[OFF_W-1:0];
         return r;
      endfunction

      // Called for every request word taken by the block.
      function void note_byte(logic [7:0] b, logic is_last);
         if (!overflow) begin
            if (offset >= MAX_REQUEST) overflow = 1;
            else scan_byte(b);
         end
         if (!is_last) begin
            if (!overflow) offset = offset + 1'b1;
         end else begin
            expected_q.push_back(summarize());
            restart();
         end
      endfunction

      // Called for every result word taken from the block.
      function void check_result(rsp_word_type got);
         rsp_word_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %p", got);
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("result %0d mismatch: expected %p, got %p", checked, want, got);
         end
         checked++;
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_word_type     req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_word_type     rsp_data;
   logic             csr_write;
   logic             csr_index;
   logic [CAP_W-1:0] csr_wdata;

   locator_scoreboard sb;
   logic [7:0]        req_text[$];   // request under construction
   int                burst_left = 0;
   bit                gaps_on = 1;
   bit                hold_off_go = 0;
   string             odd_words[4] = '{"head", "put", "option", "gett"};

   http_request_line_locator_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Request construction
   // ---------------------------------------------------------------------
   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) req_text.push_back(8'(s.getc(i)));
   endfunction

   function automatic void add_crlf();
      req_text.push_back(CH_CR);
      req_text.push_back(CH_LF);
   endfunction

   // Mixed case, with the odd letter swapped out so near misses show up.
   function automatic void add_word(string w);
      logic [7:0] c;
      for (int i = 0; i < w.len(); i++) begin
         c = 8'(w.getc(i));
         if ($urandom_range(0, 1) == 1) c = c - CASE_OFFSET;
         if ($urandom_range(0, 24) == 0) c = 8'($urandom_range(65, 122));
         req_text.push_back(c);
      end
   endfunction

   function automatic logic [7:0] path_char();
      case ($urandom_range(0, 19))
         0:       return CH_SLASH;
         1:       return 8'h2e;
         2:       return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(97, 122));
      endcase
   endfunction

   function automatic void repeat_char(logic [7:0] c, int n);
      repeat (n) req_text.push_back(c);
   endfunction

   // Mostly well-formed request lines with random content; a fifth is noise,
   // and a few are cut short at a random byte.
   function automatic void build_random_request();
      int n;
      req_text.delete();
      if ($urandom_range(0, 9) < 2) begin
         n = $urandom_range(1, 24);
         repeat (n)
            req_text.push_back($urandom_range(0, 1) == 1 ? 8'($urandom_range(0, 255)) :
                               SPECIAL_BYTES[$urandom_range(0, SPECIAL_COUNT - 1)]);
         return;
      end
      if ($urandom_range(0, 3) == 0) repeat_char(CH_SPACE, $urandom_range(1, 3));
      case ($urandom_range(0, 7))
         0, 1, 2: add_word("get");
         3, 4:    add_word("post");
         5:       add_word("options");
         6:       add_word(odd_words[$urandom_range(0, 3)]);
         default: add_word("po");
      endcase
      case ($urandom_range(0, 9))
         0:       ;
         1:       repeat_char(CH_SPACE, 2);
         default: req_text.push_back(CH_SPACE);
      endcase
      if ($urandom_range(0, 9) != 0) req_text.push_back(CH_SLASH);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      repeat (n) req_text.push_back(path_char());
      if ($urandom_range(0, 1) == 1) begin
         req_text.push_back(CH_QUESTION);
         repeat ($urandom_range(0, 10)) req_text.push_back(path_char());
      end
      case ($urandom_range(0, 7))
         0:       return;
         1:       req_text.push_back(CH_CR);
         2:       req_text.push_back(CH_LF);
         default: req_text.push_back(CH_SPACE);
      endcase
      if ($urandom_range(0, 1) == 1) add_text("HTTP/1.1");
      add_crlf();
      if ($urandom_range(0, 3) == 0) begin
         add_text("Host: h");
         add_crlf();
      end
      if ($urandom_range(0, 5) != 0) add_crlf();
      repeat ($urandom_range(0, 4)) req_text.push_back(path_char());
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, req_text.size());
         while (req_text.size() > n) void'(req_text.pop_back());
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request channel driver
   // ---------------------------------------------------------------------
   // Offer one word and hold it until the block takes it. The sender runs in
   // bursts; at the end of a burst drop valid for a random gap.
   task automatic push_byte(logic [7:0] b, logic is_last);
      req_word_type w;
      int           gap;
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) :
                                                    $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      w.req_byte = b;
      w.last     = is_last;
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b, is_last);
   endtask

   task automatic send_text();
      for (int i = 0; i < req_text.size(); i++)
         push_byte(req_text[i], i == req_text.size() - 1);
   endtask

   task automatic send_line(string s);
      req_text.delete();
      add_text(s);
      send_text();
   endtask

   // Stop offering, wait for every owed summary, then let the pipeline
   // empty before anything touches the registers.
   task automatic settle_outstanding();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both capacity registers, back to back; the block is idle here.
   task automatic set_capacities(logic [CAP_W-1:0] uri_cap, logic [CAP_W-1:0] query_cap);
      csr_write <= 1'b1;
      csr_index <= CSR_URI_CAPACITY;
      csr_wdata <= uri_cap;
      @(posedge clock);
      csr_index <= CSR_QUERY_CAPACITY;
      csr_wdata <= query_cap;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.set_capacities(uri_cap, query_cap);
   endtask

   // ---------------------------------------------------------------------
   // Directed requests, run at the reset capacities of 256
   // ---------------------------------------------------------------------
   task automatic run_directed();
      send_line("GET /index.html?a=1 HTTP/1.1\015\012\015\012");
      send_line("  post /form HTTP/1.1\015\012Host: x\015\012\015\012k=v");
      // POST whose blank line is the end of the request: no body
      send_line("POST /x HTTP/1.1\015\012\015\012");
      send_line("OPTIONS /a");
      send_line("options/");              // slash on the final byte
      send_line("OPTIONS");               // too short for its method
      send_line("GET /");
      send_line("Get/abc");               // slash right after the method
      send_line("GE/abc");
      send_line("   ");                   // nothing but leading spaces
      send_line("GET /a?");               // query never terminated
      send_line("GET /a? x");             // empty query
      send_line("gEt /p?q=1?r=2 z");      // query stops at its first separator
      send_line("GET abc");
      send_line("G");
      send_line("HEAD /");
      send_line("PosT /a\015\012\015\012X");
      send_line("POST /a\012\015\012\015\012\015\012b");
      send_line("\015\012\015\012GET /");
      send_line("OPTIONS /x?y\015");
      // zero bytes are ordinary request bytes
      req_text.delete();
      add_text("GET /a");
      req_text.push_back(8'h00);
      add_text("b?c");
      req_text.push_back(8'h00);
      add_text(" ");
      send_text();
      req_text.delete();
      req_text.push_back(8'h00);
      send_text();
      req_text.delete();
      req_text.push_back(8'hff);
      send_text();
      // URI length one below and at the capacity
      for (int n = 254; n <= 255; n++) begin
         req_text.delete();
         add_text("GET /");
         repeat_char(8'h75, n);
         add_text(" x");
         send_text();
      end
      // query length one below and at the capacity
      for (int n = 255; n <= 256; n++) begin
         req_text.delete();
         add_text("GET /?");
         repeat_char(8'h71, n);
         add_text(" x");
         send_text();
      end
   endtask

   // Largest scanned request, then one byte over and a few more.
   task automatic run_long_requests();
      req_text.delete();
      add_text("GET /");
      repeat (3000) req_text.push_back(8'($urandom_range(97, 122)));
      req_text.push_back(CH_QUESTION);
      repeat (1000) req_text.push_back(8'($urandom_range(97, 122)));
      req_text.push_back(CH_SPACE);
      while (req_text.size() < MAX_REQUEST) req_text.push_back(8'h78);
      send_text();
      req_text.delete();
      add_text("GET /");
      while (req_text.size() < MAX_REQUEST + 1) req_text.push_back(8'h79);
      send_text();
      req_text.delete();
      add_text("POST /");
      while (req_text.size() < MAX_REQUEST + 4)
         req_text.push_back(8'($urandom_range(0, 255)));
      send_text();
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int uri_cap, query_cap, phase_bytes, phase_requests;
      sb = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_URI_CAPACITY;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      settle_outstanding();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       begin uri_cap = 256;  query_cap = 256;  end
            1:       begin uri_cap = 8191; query_cap = 8191; end
            2:       begin uri_cap = 1;    query_cap = 1;    end
            3:       begin uri_cap = 0;    query_cap = 0;    end
            4:       begin uri_cap = 6;    query_cap = 3;    end
            5:       begin uri_cap = 4096; query_cap = 4096; end
            default: begin
               uri_cap   = $urandom_range(2, 40);
               query_cap = $urandom_range(0, 20);
            end
         endcase
         set_capacities(uri_cap[CAP_W-1:0], query_cap[CAP_W-1:0]);

         if (p == 0) begin
            // Receiver holds off while short requests stream in back to back,
            // so the pipeline fills and the block has to stall its input.
            hold_off_go = 1;
            gaps_on     = 0;
            repeat (12) send_line("GET /h?q ");
            gaps_on = 1;
         end
         if (p == 5) run_long_requests();

         phase_bytes    = 0;
         phase_requests = 0;
         while (phase_bytes < 85 || phase_requests < 7) begin
            build_random_request();
            phase_bytes += req_text.size();
            phase_requests++;
            send_text();
         end
         settle_outstanding();
      end

      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("http_request_line_locator_unit_tb passed");
      end else begin
         if (sb.expected_q.size() != 0)
            $display("%0d expected results never arrived", sb.expected_q.size());
         $display("http_request_line_locator_unit_tb failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result channel: check every taken word, stall on a pattern of its own
   // ---------------------------------------------------------------------
   initial begin : receiver
      int hold_left, span_left, mode;
      hold_left = 0;
      span_left = 0;
      mode      = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (hold_off_go) begin
            hold_left   = HOLD_OFF_CYCLES;
            hold_off_go = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            // spans of free flow, light stalling and heavy stalling
            if (span_left == 0) begin
               span_left = $urandom_range(8, 60);
               mode      = $urandom_range(0, 2);
            end
            span_left--;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin : watchdog
      #10_000_000;
      $display("http_request_line_locator_unit_tb failed");
      $finish;
   end

endmodule

// File: files.f
rtl/hrll_pkg.sv
rtl/hrll_scan.sv
rtl/hrll_result.sv
rtl/http_request_line_locator_unit.sv
rtl/hrll_checker.sv
bench/http_request_line_locator_unit_tb.sv
